FILE: design/assert_macros.svh
// Assertion helpers for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication check, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/erf_pkg.sv
package erf_pkg;

  localparam int DegA = 21;
  localparam int DegB = 17;
  localparam int NumSteps = DegA;
  localparam int StepW = 5;

  localparam logic [31:0] XTwo   = 32'd536870912;
  localparam logic [31:0] XThree = 32'd805306368;
  localparam logic [31:0] XFour  = 32'd1073741824;
  localparam logic [31:0] XFive  = 32'd1342177280;
  localparam logic [31:0] XSix   = 32'd1610612736;
  localparam logic [31:0] OutOne = 32'd2147483648;

  // one Horner item traveling down the pipe
  typedef struct packed {
    logic               sat_one;
    logic               use_b;
    logic signed [28:0] z;
    logic signed [63:0] acc;
  } erf_item_t;

  // coefficient of step k (k counts down degree), zero padding for short poly
  function automatic logic signed [63:0] coef_a(input logic [StepW-1:0] k);
    logic signed [63:0] c;
    case (k)
      5'd0:  c = 64'sd4611584143991239453;
      5'd1:  c = 64'sd642191352677014;
      5'd2:  c = -64'sd1926574058066741;
      5'd3:  c = 64'sd3639084332560922;
      5'd4:  c = -64'sd4816435144833904;
      5'd5:  c = 64'sd4687996859915426;
      5'd6:  c = -64'sd3403614173753262;
      5'd7:  c = 64'sd1801193988915941;
      5'd8:  c = -64'sd621549554355570;
      5'd9:  c = 64'sd64133375624077;
      5'd10: c = 64'sd72017029290667;
      5'd11: c = -64'sd49774069815178;
      5'd12: c = 64'sd13977080059636;
      5'd13: c = 64'sd563330721824;
      5'd14: c = -64'sd2087590706977;
      5'd15: c = 64'sd771939266847;
      5'd16: c = -64'sd42473753371;
      5'd17: c = -64'sd75433117048;
      5'd18: c = 64'sd27139763121;
      5'd19: c = 64'sd1278574864;
      5'd20: c = -64'sd1972273749;
      5'd21: c = -64'sd432;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [63:0] coef_b(input logic [StepW-1:0] k);
    logic signed [63:0] c;
    case (k)
      5'd0:  c = 64'sd4611686018420297616;
      5'd1:  c = 64'sd72262420;
      5'd2:  c = -64'sd361344602;
      5'd3:  c = 64'sd1180720252;
      5'd4:  c = -64'sd2830566106;
      5'd5:  c = 64'sd5302366920;
      5'd6:  c = -64'sd8089848712;
      5'd7:  c = 64'sd10323002055;
      5'd8:  c = -64'sd11135185460;
      5'd9:  c = 64'sd10270164575;
      5'd10: c = -64'sd8383436039;
      5'd11: c = 64'sd6121117123;
      5'd12: c = -64'sd3681997889;
      5'd13: c = 64'sd1775968047;
      5'd14: c = -64'sd920682351;
      5'd15: c = 64'sd504174510;
      5'd16: c = -64'sd138614959;
      5'd17: c = -64'sd392;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: design/erf_stage.sv
`include "assert_macros.svh"
// One Horner step: acc <- c[k] + floor(acc*z / 2^28), split over two registers.
// Product is built from two partial products of the 64-bit acc by 29-bit z.
module erf_stage
  import erf_pkg::*;
#(
  parameter int K = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  erf_item_t in_item,
  output logic      out_valid,
  output erf_item_t out_item
);

  // B polynomial steps: degree 17 down, so B's step k valid only when k < DegB
  localparam logic [StepW-1:0] KIdx = StepW'(K);

  // partial products, first register
  logic signed [63:0] lo_prod;  // unsigned low 32 bits times signed z
  logic signed [63:0] hi_prod;  // signed high 32 bits times signed z
  logic               mid_valid;
  erf_item_t          mid_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
    mid_item <= in_item;
    lo_prod  <= $signed({1'b0, in_item.acc[31:0]}) * in_item.z;
    hi_prod  <= $signed(in_item.acc[63:32]) * in_item.z;
  end

  // combine: floor((hi*2^32 + lo) / 2^28)
  logic signed [95:0] full_prod;
  logic signed [63:0] shifted;
  logic signed [63:0] coef;
  logic               b_active;
  erf_item_t          item_next;

  always_comb begin
    full_prod = ($signed({{32{hi_prod[63]}}, hi_prod}) <<< 32)
              + $signed({{32{lo_prod[63]}}, lo_prod});
    shifted   = full_prod[91:28];
    coef      = mid_item.use_b ? coef_b(KIdx) : coef_a(KIdx);
    // B runs four fewer steps; before its top it passes its start value through
    b_active  = !mid_item.use_b || (K < DegB);
    item_next     = mid_item;
    item_next.acc = b_active ? coef + shifted : mid_item.acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= mid_valid;
    end
    out_item <= item_next;
  end

  `ASSERT_NEXT(a_valid_flow, clk, rst, in_valid, mid_valid, "stage lost an item")

endmodule

FILE: design/erf_front.sv
// Clamp input, select range, form z and the leading coefficient.
module erf_front
  import erf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x_value,
  output logic        out_valid,
  output erf_item_t   out_item
);

  logic [31:0] xc;
  erf_item_t   item_next;

  always_comb begin
    xc = (x_value < XTwo) ? XTwo : x_value;
    item_next.sat_one = (xc >= XSix);
    item_next.use_b   = (xc >= XFour);
    item_next.z       = item_next.use_b ? 29'(xc - XFive) : 29'(xc - XThree);
    item_next.acc     = item_next.use_b ? coef_b(StepW'(DegB)) : coef_a(StepW'(DegA));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= start;
    end
    out_item <= item_next;
  end

endmodule

FILE: design/erf_large_argument_piecewise_poly_top.sv
// Throughput: one item per cycle; busy is always low; set by the Horner pipe,
// 21 steps of two registers each (partial product, then add).
// Reset (rst, synchronous, active high) clears all valid bits; strobe is low.
// The receiver cannot stall: each result shows for one cycle with strobe.
`include "assert_macros.svh"
module erf_large_argument_piecewise_poly_top
  import erf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x_value,
  output logic        busy,
  output logic        strobe,
  output logic [31:0] erf_value
);

  logic      v [NumSteps+1];
  erf_item_t it [NumSteps+1];

  erf_front u_front (
    .clk(clk), .rst(rst), .start(start), .x_value(x_value),
    .out_valid(v[0]), .out_item(it[0])
  );

  // step for coefficient index DegA-1-g
  for (genvar g = 0; g < NumSteps; g++) begin : g_step
    erf_stage #(.K(NumSteps - 1 - g)) u_stage (
      .clk(clk), .rst(rst), .in_valid(v[g]), .in_item(it[g]),
      .out_valid(v[g+1]), .out_item(it[g+1])
    );
  end

  // round half up, saturate into Q1.31
  erf_item_t   fin;
  logic [32:0] rnd;
  logic [31:0] res_next;

  always_comb begin
    fin = it[NumSteps];
    rnd = 33'((fin.acc + 64'sd1073741824) >>> 31);
    if (fin.sat_one) begin
      res_next = OutOne;
    end else if (fin.acc[63]) begin
      res_next = '0;
    end else if (rnd > {1'b0, OutOne}) begin
      res_next = OutOne;
    end else begin
      res_next = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= v[NumSteps];
    end
    erf_value <= res_next;
  end

  assign busy = 1'b0;

  `ASSERT_IMPL(a_range, clk, rst, strobe, erf_value <= OutOne, "result above one")
  `ASSERT_NEXT(a_last, clk, rst, v[NumSteps], strobe, "final item dropped")

endmodule
